/* rtl/osq_pkg.sv */
// ---------------------------------------------------------------------------
// osq_pkg
// shared types and codes for the ordered sleep queue
// ---------------------------------------------------------------------------
package osq_pkg;

    localparam logic [1:0] ACT_SLEEP  = 2'd0;
    localparam logic [1:0] ACT_TICK   = 2'd1;
    localparam logic [1:0] ACT_CANCEL = 2'd2;
    localparam logic [1:0] ACT_EARLY  = 2'd3;

    localparam logic [2:0] KIND_NONE     = 3'd0;
    localparam logic [2:0] KIND_SLEPT    = 3'd1;
    localparam logic [2:0] KIND_NOT_RUN  = 3'd2;
    localparam logic [2:0] KIND_COERCING = 3'd3;
    localparam logic [2:0] KIND_ZERO_NAP = 3'd4;
    localparam logic [2:0] KIND_WOKE     = 3'd5;
    localparam logic [2:0] KIND_CANCEL   = 3'd6;
    localparam logic [2:0] KIND_EARLY    = 3'd7;

    // wake time source of a result word
    localparam logic [1:0] WT_ZERO  = 2'd0;
    localparam logic [1:0] WT_STORE = 2'd1;
    localparam logic [1:0] WT_NEW   = 2'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [3:0]  process;
        logic [31:0] nap_ticks;
        logic [31:0] now_ticks;
        logic        proc_running;
        logic        coercion_done;
        logic [3:0]  front_process;
        logic        front_event_pending;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  slot;
        logic [31:0] wake_time;
        logic        last;
    } t_out_word;

    typedef struct packed {
        logic       ld_item;
        logic       tick_init;
        logic       ins_init;
        logic       c_next;
        logic       c_nx;
        logic       p_from_c;
        logic       lat_nx;
        logic       set_s_cur;
        logic       set_s_front;
        logic       unl_rd;
        logic       unl_wr;
        logic       ins_wr;
        logic       wake_wr;
        logic       wake_new;
        logic       flag_set;
        logic       flag_clr;
        logic       push;
        logic [2:0] kind;
        logic [1:0] wt_sel;
        logic       finish;
    } t_cmd;

    typedef struct packed {
        logic [1:0] action;
        logic       in_range;
        logic       s_asleep;
        logic       running;
        logic       coerce_ok;
        logic       nap_zero;
        logic       cur_ok;
        logic       cur_due;
        logic       ins_stop;
        logic       flag;
        logic       front_ok;
        logic       can_push;
        logic       pend_v;
        logic       out_free;
    } t_sts;

endpackage

/* rtl/osq_ctrl.sv */
// ---------------------------------------------------------------------------
// osq_ctrl
// sequencer for sleep, tick, cancel and early wake handling
// ---------------------------------------------------------------------------
module osq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  osq_pkg::t_sts  i_sts,
    output osq_pkg::t_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DEC   = 4'd1;
    localparam logic [3:0] S_U_RD  = 4'd2;
    localparam logic [3:0] S_U_WR  = 4'd3;
    localparam logic [3:0] S_SL_WR = 4'd4;
    localparam logic [3:0] S_WALK  = 4'd5;
    localparam logic [3:0] S_LINK  = 4'd6;
    localparam logic [3:0] S_EMIT  = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;
    localparam logic [3:0] S_T_CHK = 4'd9;
    localparam logic [3:0] S_T_ADV = 4'd10;
    localparam logic [3:0] S_FRONT = 4'd11;
    localparam logic [3:0] S_ZW    = 4'd12;

    logic [3:0] r_state, n_state;
    logic [3:0] r_uret, n_uret;
    logic [3:0] r_eret, n_eret;
    logic [2:0] r_kind, n_kind;
    logic [1:0] r_wsel, n_wsel;

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_uret  <= S_IDLE;
            r_eret  <= S_IDLE;
            r_kind  <= osq_pkg::KIND_NONE;
            r_wsel  <= osq_pkg::WT_ZERO;
        end else begin
            r_state <= n_state;
            r_uret  <= n_uret;
            r_eret  <= n_eret;
            r_kind  <= n_kind;
            r_wsel  <= n_wsel;
        end
    end

    always_comb begin
        n_state = r_state;
        n_uret  = r_uret;
        n_eret  = r_eret;
        n_kind  = r_kind;
        n_wsel  = r_wsel;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.ld_item = 1'b1;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_eret = S_FIN;
                if (i_sts.action == osq_pkg::ACT_TICK) begin
                    o_cmd.tick_init = 1'b1;
                    n_state = S_T_CHK;
                end else if (!i_sts.in_range) begin
                    n_kind  = osq_pkg::KIND_NONE;
                    n_wsel  = osq_pkg::WT_ZERO;
                    n_state = S_EMIT;
                end else if (i_sts.action == osq_pkg::ACT_SLEEP) begin
                    n_wsel = osq_pkg::WT_STORE;
                    if (!i_sts.running) begin
                        n_kind  = osq_pkg::KIND_NOT_RUN;
                        n_state = S_EMIT;
                    end else if (!i_sts.coerce_ok) begin
                        n_kind  = osq_pkg::KIND_COERCING;
                        n_state = S_EMIT;
                    end else if (i_sts.nap_zero) begin
                        n_kind  = osq_pkg::KIND_ZERO_NAP;
                        n_state = S_EMIT;
                    end else begin
                        n_uret  = S_SL_WR;
                        n_state = i_sts.s_asleep ? S_U_RD : S_SL_WR;
                    end
                end else if (i_sts.action == osq_pkg::ACT_CANCEL) begin
                    n_kind  = osq_pkg::KIND_CANCEL;
                    n_uret  = S_ZW;
                    n_state = i_sts.s_asleep ? S_U_RD : S_ZW;
                end else begin
                    o_cmd.wake_wr  = 1'b1;
                    o_cmd.flag_set = 1'b1;
                    n_kind  = osq_pkg::KIND_EARLY;
                    n_wsel  = osq_pkg::WT_ZERO;
                    n_state = S_EMIT;
                end
            end
            S_U_RD: begin
                o_cmd.unl_rd = 1'b1;
                n_state = S_U_WR;
            end
            S_U_WR: begin
                o_cmd.unl_wr = 1'b1;
                n_state = r_uret;
            end
            S_SL_WR: begin
                o_cmd.wake_wr  = 1'b1;
                o_cmd.wake_new = 1'b1;
                o_cmd.ins_init = 1'b1;
                n_state = S_WALK;
            end
            S_WALK: begin
                if (i_sts.cur_ok && !i_sts.ins_stop) begin
                    o_cmd.p_from_c = 1'b1;
                    o_cmd.c_next   = 1'b1;
                end else begin
                    n_state = S_LINK;
                end
            end
            S_LINK: begin
                o_cmd.ins_wr = 1'b1;
                n_kind  = osq_pkg::KIND_SLEPT;
                n_wsel  = osq_pkg::WT_NEW;
                n_eret  = S_FIN;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.can_push) begin
                    o_cmd.push   = 1'b1;
                    o_cmd.kind   = r_kind;
                    o_cmd.wt_sel = r_wsel;
                    n_state = r_eret;
                end
            end
            S_FIN: begin
                if (!i_sts.pend_v) begin
                    n_state = S_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_T_CHK: begin
                if (!i_sts.cur_ok) begin
                    n_state = S_FRONT;
                end else if (i_sts.cur_due) begin
                    o_cmd.set_s_cur = 1'b1;
                    o_cmd.lat_nx    = 1'b1;
                    n_kind  = osq_pkg::KIND_WOKE;
                    n_wsel  = osq_pkg::WT_STORE;
                    n_uret  = S_EMIT;
                    n_eret  = S_T_ADV;
                    n_state = S_U_RD;
                end else if (i_sts.flag) begin
                    o_cmd.c_next = 1'b1;
                end else begin
                    n_state = S_FRONT;
                end
            end
            S_T_ADV: begin
                o_cmd.c_nx = 1'b1;
                n_state = S_T_CHK;
            end
            S_FRONT: begin
                o_cmd.flag_clr = 1'b1;
                if (i_sts.front_ok) begin
                    o_cmd.set_s_front = 1'b1;
                    n_kind  = osq_pkg::KIND_CANCEL;
                    n_uret  = S_ZW;
                    n_state = S_U_RD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_ZW: begin
                o_cmd.wake_wr = 1'b1;
                n_wsel  = osq_pkg::WT_ZERO;
                n_eret  = S_FIN;
                n_state = S_EMIT;
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

/* rtl/osq_dp.sv */
// ---------------------------------------------------------------------------
// osq_dp
// linked list stores, walk registers and result staging
// ---------------------------------------------------------------------------
module osq_dp #(
    parameter int MAX_PROCS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  osq_pkg::t_cmd       i_cmd,
    output osq_pkg::t_sts       o_sts,
    input  osq_pkg::t_in_word   i_in_data,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output osq_pkg::t_out_word  o_out_data
);

    localparam int IW = $clog2(MAX_PROCS);
    localparam int LW = $clog2(MAX_PROCS + 1);
    localparam int SW = (LW > 4) ? LW : 4;
    localparam logic [LW-1:0] NIL = LW'(MAX_PROCS);

    logic [MAX_PROCS-1:0] r_asleep;
    logic [31:0]          r_wake [MAX_PROCS];
    logic [LW-1:0]        r_next [MAX_PROCS];
    logic [LW-1:0]        r_prev [MAX_PROCS];
    logic [LW-1:0]        r_head;
    logic                 r_flag;

    osq_pkg::t_in_word    r_item;
    logic [31:0]          r_t;
    logic [SW-1:0]        r_s;
    logic [LW-1:0]        r_c, r_p, r_nx, r_up, r_un;
    logic [LW-1:0]        r_steps;

    osq_pkg::t_out_word   r_pend, r_out, n_res;
    logic                 r_pend_v, r_out_v;

    logic [32:0]          w_sum;
    logic [IW-1:0]        w_si, w_ci, w_fi;
    logic [LW-1:0]        w_cl, w_sl;
    logic [31:0]          w_cw;
    logic                 w_out_free;

    assign w_sum = 33'(i_in_data.nap_ticks) + 33'(i_in_data.now_ticks);
    assign w_si  = r_s[IW-1:0];
    assign w_ci  = r_c[IW-1:0];
    assign w_fi  = IW'(r_item.front_process);
    assign w_sl  = LW'(r_s);
    assign w_cl  = (r_c >= NIL) ? NIL : r_c;
    assign w_cw  = r_wake[w_ci];
    assign w_out_free = !r_out_v || i_out_ready;

    always_comb begin
        o_sts.action    = r_item.action;
        o_sts.in_range  = 32'(r_item.process) < 32'(MAX_PROCS);
        o_sts.s_asleep  = r_asleep[w_si];
        o_sts.running   = r_item.proc_running;
        o_sts.coerce_ok = r_item.coercion_done;
        o_sts.nap_zero  = (r_item.nap_ticks == 32'd0);
        o_sts.cur_ok    = (r_c < NIL) && (r_steps < NIL);
        o_sts.cur_due   = w_cw <= r_item.now_ticks;
        o_sts.ins_stop  = (w_cw != 32'd0) && (w_cw > r_t);
        o_sts.flag      = r_flag;
        o_sts.front_ok  = (32'(r_item.front_process) < 32'(MAX_PROCS)) &&
                          r_asleep[w_fi] && r_item.front_event_pending;
        o_sts.can_push  = !r_pend_v || w_out_free;
        o_sts.pend_v    = r_pend_v;
        o_sts.out_free  = w_out_free;
    end

    always_comb begin
        n_res.kind = i_cmd.kind;
        n_res.slot = 4'(r_s);
        n_res.last = 1'b0;
        case (i_cmd.wt_sel)
            osq_pkg::WT_STORE: n_res.wake_time = r_wake[w_si];
            osq_pkg::WT_NEW:   n_res.wake_time = r_t;
            default:           n_res.wake_time = 32'd0;
        endcase
    end

    // walk and item registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_item) begin
            r_item <= i_in_data;
            r_t    <= w_sum[32] ? 32'hFFFF_FFFF : w_sum[31:0];
            r_s    <= SW'(i_in_data.process);
        end
        if (i_cmd.set_s_cur)   r_s <= SW'(r_c);
        if (i_cmd.set_s_front) r_s <= SW'(r_item.front_process);
        if (i_cmd.tick_init || i_cmd.ins_init) begin
            r_c     <= r_head;
            r_steps <= '0;
        end
        if (i_cmd.ins_init) r_p <= NIL;
        if (i_cmd.p_from_c) r_p <= r_c;
        if (i_cmd.c_next) begin
            r_c     <= r_next[w_ci];
            r_steps <= r_steps + 1'b1;
        end
        if (i_cmd.c_nx) begin
            r_c     <= r_nx;
            r_steps <= r_steps + 1'b1;
        end
        if (i_cmd.lat_nx) r_nx <= r_next[w_ci];
        if (i_cmd.unl_rd) begin
            r_up <= r_prev[w_si];
            r_un <= r_next[w_si];
        end
    end

    // link stores, written in statement order so that on an unlink the named entry wins
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_PROCS; i++) begin
            if (i_cmd.unl_wr) begin
                if (r_up == LW'(i)) r_next[i] <= r_un;
                if (r_un == LW'(i)) r_prev[i] <= r_up;
                if (r_s == SW'(i)) begin
                    r_next[i] <= NIL;
                    r_prev[i] <= NIL;
                end
            end
            if (i_cmd.ins_wr) begin
                if (r_s == SW'(i)) begin
                    r_prev[i] <= r_p;
                    r_next[i] <= w_cl;
                end
                if (r_p == LW'(i)) r_next[i] <= w_sl;
                if (w_cl == LW'(i)) r_prev[i] <= w_sl;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_asleep <= '0;
            for (int i = 0; i < MAX_PROCS; i++) r_wake[i] <= 32'd0;
            r_head   <= NIL;
            r_flag   <= 1'b0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            for (int i = 0; i < MAX_PROCS; i++) begin
                if (r_s == SW'(i)) begin
                    if (i_cmd.unl_wr) r_asleep[i] <= 1'b0;
                    if (i_cmd.ins_wr) r_asleep[i] <= 1'b1;
                    if (i_cmd.wake_wr) r_wake[i] <= i_cmd.wake_new ? r_t : 32'd0;
                end
            end
            if (i_cmd.unl_wr && (r_up >= NIL)) r_head <= r_un;
            if (i_cmd.ins_wr && (r_p >= NIL))  r_head <= w_sl;
            if (i_cmd.flag_set) r_flag <= 1'b1;
            if (i_cmd.flag_clr) r_flag <= 1'b0;
            if (i_cmd.push) begin
                r_pend_v <= 1'b1;
                r_out_v  <= r_pend_v || (r_out_v && !i_out_ready);
            end else if (i_cmd.finish) begin
                r_pend_v <= 1'b0;
                r_out_v  <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v  <= 1'b0;
            end
        end
    end

    // result staging: the held word goes out once the next one is known, or with
    // last set when the action finishes (a held word always has last clear)
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_pend <= n_res;
            if (r_pend_v) r_out <= r_pend;
        end else if (i_cmd.finish) begin
            r_out <= '{kind: r_pend.kind, slot: r_pend.slot,
                       wake_time: r_pend.wake_time, last: 1'b1};
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

endmodule

/* rtl/ordered_sleep_queue.sv */
// ---------------------------------------------------------------------------
// ordered_sleep_queue
// timer queue of sleeping process slots kept as a list sorted by wake time
// ---------------------------------------------------------------------------
// usage
//   input channel: one word per action (sleep, tick, cancel, early wake mark)
//   on i_in_valid / o_in_ready; taken only while the sequencer is idle
//   output channel: result words on o_out_valid / i_out_ready, the final
//   word of an action carries last; a tick that does nothing gives none
//   a cancel or a sleep unlinks the slot first if it sleeps; a sleep then
//   walks the list one entry a cycle to find its place and relinks there;
//   a tick walks the list, waking each due entry, and passes entries not
//   yet due only while the nap-over flag is set
//   throughput: one action at a time, set by the list walk sequencer
//   results are held one word back so last can be set; a stalled receiver
//   freezes the sequencer at its next result word, nothing is dropped
//   reset clears sleep bits, wake times, the head link and the nap-over flag
// ---------------------------------------------------------------------------
module ordered_sleep_queue #(
    parameter int MAX_PROCS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  osq_pkg::t_in_word   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output osq_pkg::t_out_word  o_out_data
);

    // command and status between sequencer and datapath
    osq_pkg::t_cmd w_cmd;
    osq_pkg::t_sts w_sts;

    osq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // list stores, walk pointers and output staging
    osq_dp #(
        .MAX_PROCS (MAX_PROCS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

/* dv/ordered_sleep_queue_tb.sv */
// ---------------------------------------------------------------------------
// ordered_sleep_queue_tb
// self-checking bench for the ordered sleep queue: a local model of the
// sorted sleep list predicts every result word, a monitor compares them
// ---------------------------------------------------------------------------
module ordered_sleep_queue_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPROC = 16;
    localparam int NIL = NPROC;
    localparam int CYCLE_LIMIT = 400000;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    osq_pkg::t_in_word   i_in_data;
    logic                o_out_valid;
    logic                i_out_ready;
    osq_pkg::t_out_word  o_out_data;

    ordered_sleep_queue #(.MAX_PROCS(NPROC)) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    // model of the sleep list
    logic        m_asleep [NPROC];
    logic [31:0] m_wake   [NPROC];
    int          m_next   [NPROC];
    int          m_prev   [NPROC];
    int          m_head;
    logic        m_nap_over;

    osq_pkg::t_out_word expected_words[$];
    int          mismatch_count;
    int          words_checked;
    int          items_sent;
    int          cycle_count;
    bit          no_idle;   // set during the stretch with no idling

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog over the whole run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // --- list model ---------------------------------------------------------
    function automatic void list_remove(int s);
        int p;
        int n;
        p = m_prev[s];
        n = m_next[s];
        if (p < NPROC) m_next[p] = n;
        else m_head = n;
        if (n < NPROC) m_prev[n] = p;
        m_prev[s] = NIL;
        m_next[s] = NIL;
        m_asleep[s] = 1'b0;
    endfunction

    function automatic void list_insert(int s, logic [31:0] t);
        int p;
        int c;
        int steps;
        p = NIL;
        c = m_head;
        steps = 0;
        while (c < NPROC && steps < NPROC) begin
            if (m_wake[c] != 32'd0 && m_wake[c] > t) break;
            p = c;
            c = m_next[c];
            steps++;
        end
        if (c >= NPROC) c = NIL;
        m_prev[s] = p;
        m_next[s] = c;
        if (p < NPROC) m_next[p] = s;
        else m_head = s;
        if (c < NPROC) m_prev[c] = s;
        m_asleep[s] = 1'b1;
    endfunction

    function automatic void queue_word(logic [2:0] kind, int s, logic [31:0] wt);
        osq_pkg::t_out_word w;
        w.kind = kind;
        w.slot = s[3:0];
        w.wake_time = wt;
        w.last = 1'b0;
        expected_words.push_back(w);
    endfunction

    // predicts the result words of one accepted word
    function automatic void predict_queue_action(osq_pkg::t_in_word w);
        int          c;
        int          nx;
        int          steps;
        int          s;
        int          f;
        int          n0;
        logic [32:0] sum;
        logic [31:0] t;
        n0 = expected_words.size();
        s = int'(w.process);
        f = int'(w.front_process);
        case (w.action)
            osq_pkg::ACT_TICK: begin
                c = m_head;
                steps = 0;
                while (c < NPROC && steps < NPROC) begin
                    nx = m_next[c];
                    if (m_wake[c] <= w.now_ticks) begin
                        list_remove(c);
                        queue_word(osq_pkg::KIND_WOKE, c, m_wake[c]);
                    end else if (!m_nap_over) begin
                        break;
                    end
                    c = nx;
                    steps++;
                end
                m_nap_over = 1'b0;
                if (m_asleep[f] && w.front_event_pending &&
                    expected_words.size() - n0 < 16) begin
                    list_remove(f);
                    m_wake[f] = '0;
                    queue_word(osq_pkg::KIND_CANCEL, f, '0);
                end
            end
            osq_pkg::ACT_SLEEP: begin
                if (!w.proc_running)
                    queue_word(osq_pkg::KIND_NOT_RUN, s, m_wake[s]);
                else if (!w.coercion_done)
                    queue_word(osq_pkg::KIND_COERCING, s, m_wake[s]);
                else if (w.nap_ticks == 32'd0)
                    queue_word(osq_pkg::KIND_ZERO_NAP, s, m_wake[s]);
                else begin
                    sum = {1'b0, w.now_ticks} + {1'b0, w.nap_ticks};
                    t = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                    if (m_asleep[s]) list_remove(s);
                    m_wake[s] = t;
                    list_insert(s, t);
                    queue_word(osq_pkg::KIND_SLEPT, s, t);
                end
            end
            osq_pkg::ACT_CANCEL: begin
                if (m_asleep[s]) list_remove(s);
                m_wake[s] = '0;
                queue_word(osq_pkg::KIND_CANCEL, s, '0);
            end
            default: begin
                m_wake[s] = '0;
                m_nap_over = 1'b1;
                queue_word(osq_pkg::KIND_EARLY, s, '0);
            end
        endcase
        if (expected_words.size() > n0)
            expected_words[expected_words.size() - 1].last = 1'b1;
    endfunction

    // --- driving ------------------------------------------------------------
    function automatic bit idle_now();
        return !no_idle && ($urandom_range(99) < 30);
    endfunction

    // sends one word; predicts when it is taken
    task automatic send_word(osq_pkg::t_in_word w);
        if (idle_now()) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while (idle_now()) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_queue_action(w);
        items_sent++;
    endtask

    // receiver stalls at random
    always @(posedge i_clk) begin
        if (!i_rst_n) i_out_ready <= 1'b0;
        else i_out_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 30);
    end

    // result checker
    always @(posedge i_clk) begin
        osq_pkg::t_out_word e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            words_checked++;
            if (expected_words.size() == 0) begin
                report_mismatch($sformatf("unexpected word %p", o_out_data));
            end else begin
                e = expected_words.pop_front();
                if (o_out_data.kind !== e.kind)
                    report_mismatch($sformatf("kind %0d, want %0d", o_out_data.kind, e.kind));
                if (o_out_data.slot !== e.slot)
                    report_mismatch($sformatf("slot %0d, want %0d", o_out_data.slot, e.slot));
                if (o_out_data.wake_time !== e.wake_time)
                    report_mismatch($sformatf("wake_time %h, want %h",
                                              o_out_data.wake_time, e.wake_time));
                if (o_out_data.last !== e.last)
                    report_mismatch($sformatf("last %b, want %b", o_out_data.last, e.last));
            end
        end
    end

    function automatic osq_pkg::t_in_word make_word(logic [1:0] act, logic [3:0] p,
                                                    logic [31:0] nap, logic [31:0] now);
        osq_pkg::t_in_word w;
        w.action = act;
        w.process = p;
        w.nap_ticks = nap;
        w.now_ticks = now;
        w.proc_running = 1'b1;
        w.coercion_done = 1'b1;
        w.front_process = 4'($urandom_range(15));
        w.front_event_pending = 1'b0;
        return w;
    endfunction

    // --- tests --------------------------------------------------------------
    task automatic test_directed();
        osq_pkg::t_in_word w;
        // refusals, in priority order
        w = make_word(osq_pkg::ACT_SLEEP, 4'd0, 32'd5, 32'd0);
        w.proc_running = 1'b0;
        w.coercion_done = 1'b0;
        send_word(w);
        w.proc_running = 1'b1;
        send_word(w);
        send_word(make_word(osq_pkg::ACT_SLEEP, 4'd15, 32'd0, 32'd10));
        // sleeps, including saturation and extreme values
        send_word(make_word(osq_pkg::ACT_SLEEP, 4'd0, 32'd100, 32'd0));
        send_word(make_word(osq_pkg::ACT_SLEEP, 4'd1, 32'd50, 32'd0));
        send_word(make_word(osq_pkg::ACT_SLEEP, 4'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_word(make_word(osq_pkg::ACT_SLEEP, 4'd3, 32'd100, 32'd0));
        send_word(make_word(osq_pkg::ACT_SLEEP, 4'd15, 32'd1, 32'd0));
        // refusal while asleep reports stored time
        w = make_word(osq_pkg::ACT_SLEEP, 4'd0, 32'd7, 32'd0);
        w.proc_running = 1'b0;
        send_word(w);
        // resleep relinks
        send_word(make_word(osq_pkg::ACT_SLEEP, 4'd1, 32'd500, 32'd0));
        // early wake keeps entry linked with zero time
        send_word(make_word(osq_pkg::ACT_EARLY, 4'd3, 32'd0, 32'd0));
        send_word(make_word(osq_pkg::ACT_SLEEP, 4'd4, 32'd10, 32'd0));
        // tick with nap-over scanning past entries not yet due
        send_word(make_word(osq_pkg::ACT_TICK, 4'd0, 32'd0, 32'd20));
        // tick that does nothing
        send_word(make_word(osq_pkg::ACT_TICK, 4'd0, 32'd0, 32'd0));
        // cancel asleep and awake slots
        send_word(make_word(osq_pkg::ACT_CANCEL, 4'd0, 32'd0, 32'd0));
        send_word(make_word(osq_pkg::ACT_CANCEL, 4'd9, 32'd0, 32'd0));
        // tick with event pending for the front slot
        w = make_word(osq_pkg::ACT_TICK, 4'd0, 32'd0, 32'd1);
        w.front_process = 4'd2;
        w.front_event_pending = 1'b1;
        send_word(w);
        // early wake of a sleeping slot, then a full sweep
        send_word(make_word(osq_pkg::ACT_EARLY, 4'd1, 32'd0, 32'd0));
        send_word(make_word(osq_pkg::ACT_TICK, 4'd0, 32'd0, 32'hFFFF_FFFF));
    endtask

    function automatic osq_pkg::t_in_word random_word();
        osq_pkg::t_in_word w;
        int r;
        w = make_word(osq_pkg::ACT_SLEEP, 4'($urandom_range(15)),
                      32'($urandom_range(200)), 32'($urandom_range(400)));
        r = $urandom_range(99);
        if (r < 45) w.action = osq_pkg::ACT_SLEEP;
        else if (r < 75) w.action = osq_pkg::ACT_TICK;
        else if (r < 88) w.action = osq_pkg::ACT_CANCEL;
        else w.action = osq_pkg::ACT_EARLY;
        if ($urandom_range(9) == 0) w.nap_ticks = $urandom();
        if ($urandom_range(9) == 0) w.now_ticks = $urandom();
        if ($urandom_range(19) == 0) w.nap_ticks = '0;
        w.proc_running = $urandom_range(9) != 0;
        w.coercion_done = $urandom_range(9) != 0;
        w.front_event_pending = $urandom_range(3) == 0;
        return w;
    endfunction

    task automatic test_random(int count);
        repeat (count) send_word(random_word());
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_ready = 1'b0;
        mismatch_count = 0;
        words_checked = 0;
        items_sent = 0;
        cycle_count = 0;
        no_idle = 1'b0;
        for (int i = 0; i < NPROC; i++) begin
            m_asleep[i] = 1'b0;
            m_wake[i] = '0;
            m_next[i] = 0;
            m_prev[i] = 0;
        end
        m_head = NIL;
        m_nap_over = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(200);
        no_idle = 1'b1;
        test_random(80);
        no_idle = 1'b0;
        test_random(170);
        wait_drain();

        $display("sent %0d action words, checked %0d result words", items_sent,
                 words_checked);
        $display("covered sleeps, refusals, ticks, cancels and early wake marks");
        if (mismatch_count == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end
endmodule

/* ordered_sleep_queue.f */
rtl/osq_pkg.sv
rtl/osq_ctrl.sv
rtl/osq_dp.sv
rtl/ordered_sleep_queue.sv
dv/ordered_sleep_queue_tb.sv
